// ===== sv/linear_convolution_modes_macros.svh =====
// Assertion macros used by the convolution engine RTL.
`ifndef LINEAR_CONVOLUTION_MODES_MACROS_SVH
`define LINEAR_CONVOLUTION_MODES_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge outside reset.
`define LCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lcm assertion failed");

// Checks that a condition leads to a consequence in the next cycle.
`define LCM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("lcm assertion failed");

`else

`define LCM_ASSERT(label, clk, rst_n, prop)
`define LCM_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

// ===== sv/lcm_pkg.sv =====
// Types and constants of the linear convolution engine.
package lcm_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_LOAD_SIG = 2'd0,
        CMD_LOAD_KER = 2'd1,
        CMD_FETCH    = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    // Convolution modes; the unused code behaves as full.
    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_CENTRAL = 2'd1;
    localparam logic [1:0] MODE_VALID   = 2'd2;

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int IDX_W      = 11;
    localparam int MODE_W     = 2;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

endpackage

// ===== sv/linear_convolution_modes.sv =====
// Top level of the linear convolution engine with full, central and valid modes.
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/tready        tuser = cmd, tdata = sample_value
//  m_axis    out        m_axis_tvalid/tready        tdata = out_value, out_index;
//                                                   tlast = is_last; tuser = flags
//  cfg       in         i_cfg_valid/o_cfg_ready     i_cfg_data = conv_mode
//
// Load and clear items are taken in S_IDLE. Reset clears counts, mode and flags;
// the stores need no clearing pass. A fetch with N product terms (at most KERNEL_DEPTH)
// passes S_SHAPE, S_RANGE, S_RUN, S_DRAIN and S_DONE, skipping from S_RANGE to S_DONE
// when N is 0; one multiply-accumulate per cycle in S_RUN, fed by the two store reads.
// A finished result waits in the output register while loads are taken; the next
// fetch finishes its sum and then waits for that register to drain.
`include "linear_convolution_modes_macros.svh"

module linear_convolution_modes #(
    parameter int SIGNAL_DEPTH = 1024,
    parameter int KERNEL_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lcm_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] sample_value
    input  logic [1:0]                          s_axis_tuser,  // [1:0] cmd
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lcm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [39:0] out_value,
                                                               // [50:40] out_index, zeros
    output logic                                m_axis_tlast,  // is_last
    output logic [lcm_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // [0] no_output,
                                                               // [1] load_overflow
    // Mode register write.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lcm_pkg::MODE_W-1:0]          i_cfg_data
);

    localparam int SAW = (SIGNAL_DEPTH > 1) ? $clog2(SIGNAL_DEPTH) : 1;
    localparam int KAW = (KERNEL_DEPTH > 1) ? $clog2(KERNEL_DEPTH) : 1;
    localparam int SCW = $clog2(SIGNAL_DEPTH + 1);
    localparam int KCW = $clog2(KERNEL_DEPTH + 1);
    localparam int NW  = $clog2(SIGNAL_DEPTH + KERNEL_DEPTH + 1);
    localparam int AW  = $clog2(SIGNAL_DEPTH + KERNEL_DEPTH + 1) + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHAPE,
        S_RANGE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [SCW-1:0]               r_sig_cnt;
    logic [KCW-1:0]               r_ker_cnt;
    logic [NW-1:0]                r_next;
    logic                         r_ovf;
    logic [lcm_pkg::MODE_W-1:0]   r_mode;
    logic [NW-1:0]                r_len;
    logic signed [AW-1:0]         r_start;
    logic [SAW-1:0]               r_j;
    logic [KAW-1:0]               r_k;
    logic [KAW-1:0]               r_left;
    logic                         r_empty;
    logic                         r_p1;
    logic                         r_p2;
    logic signed [lcm_pkg::PROD_W-1:0] r_prod;
    logic [lcm_pkg::ACC_W-1:0]    r_acc;
    logic                         r_out_valid;
    logic [lcm_pkg::ACC_W-1:0]    r_out_value;
    logic [lcm_pkg::IDX_W-1:0]    r_out_index;
    logic                         r_out_last;
    logic                         r_out_none;
    logic                         r_out_ovf;

    logic                         in_acc;
    logic                         out_free;
    lcm_pkg::t_cmd                cmd;
    logic                         sig_we;
    logic                         ker_we;
    logic                         cfg_we;
    logic                         seq_restart;
    logic [lcm_pkg::SAMPLE_W-1:0] sig_q;
    logic [lcm_pkg::SAMPLE_W-1:0] ker_q;

    logic signed [AW-1:0]         x_s;
    logic signed [AW-1:0]         h_s;
    logic signed [AW-1:0]         n_len_w;
    logic signed [AW-1:0]         n_start;
    logic signed [AW-1:0]         pos;
    logic signed [AW-1:0]         lo_raw;
    logic signed [AW-1:0]         lo;
    logic signed [AW-1:0]         hi;
    logic signed [AW-1:0]         k0;
    logic signed [AW-1:0]         span;
    logic                         n_empty;
    logic [NW+lcm_pkg::IDX_W-1:0] idx_ext;

    assign cmd           = lcm_pkg::t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid && o_cfg_ready;
    assign sig_we = in_acc && (cmd == lcm_pkg::CMD_LOAD_SIG)
                    && (r_sig_cnt < SCW'(SIGNAL_DEPTH));
    assign ker_we = in_acc && (cmd == lcm_pkg::CMD_LOAD_KER)
                    && (r_ker_cnt < KCW'(KERNEL_DEPTH));
    assign seq_restart = cfg_we || sig_we || ker_we
                         || (in_acc && (cmd == lcm_pkg::CMD_CLEAR));

    // Sample and tap stores.
    lcm_ram #(
        .WIDTH (lcm_pkg::SAMPLE_W),
        .DEPTH (SIGNAL_DEPTH)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (sig_we),
        .i_waddr (r_sig_cnt[SAW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_j),
        .o_rdata (sig_q)
    );

    lcm_ram #(
        .WIDTH (lcm_pkg::SAMPLE_W),
        .DEPTH (KERNEL_DEPTH)
    ) u_ker_ram (
        .i_clk   (i_clk),
        .i_we    (ker_we),
        .i_waddr (r_ker_cnt[KAW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_k),
        .o_rdata (ker_q)
    );

    // Sequence length and first convolution index for the current mode.
    always_comb begin
        x_s     = $signed({{(AW-SCW){1'b0}}, r_sig_cnt});
        h_s     = $signed({{(AW-KCW){1'b0}}, r_ker_cnt});
        n_len_w = '0;
        n_start = '0;
        case (r_mode)
            lcm_pkg::MODE_CENTRAL: begin
                n_len_w = x_s;
                n_start = h_s >>> 1;
            end
            lcm_pkg::MODE_VALID: begin
                n_len_w = (h_s > x_s) ? '0 : (x_s - h_s + AW'(1));
                n_start = h_s - AW'(1);
            end
            default: begin
                n_len_w = x_s + h_s - AW'(1);
                n_start = '0;
            end
        endcase
        if ((r_sig_cnt == '0) && (r_ker_cnt == '0)) begin
            n_len_w = '0;
        end
    end

    // Range of signal indexes that contribute to the requested output.
    always_comb begin
        pos     = r_start + $signed({{(AW-NW){1'b0}}, r_next});
        lo_raw  = pos - h_s + AW'(1);
        lo      = (lo_raw < 0) ? '0 : lo_raw;
        hi      = (pos < (x_s - AW'(1))) ? pos : (x_s - AW'(1));
        k0      = pos - lo;
        span    = hi - lo;
        n_empty = (r_next >= r_len);
        idx_ext = {{lcm_pkg::IDX_W{1'b0}}, r_next};
    end

    // Control, counters, multiply-accumulate pipeline and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sig_cnt   <= '0;
            r_ker_cnt   <= '0;
            r_next      <= '0;
            r_ovf       <= 1'b0;
            r_mode      <= lcm_pkg::MODE_FULL;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1 <= (r_state == S_RUN);
            r_p2 <= r_p1;
            if (r_p1) begin
                r_prod <= $signed(sig_q) * $signed(ker_q);
            end
            if (r_p2) begin
                r_acc <= r_acc + {{(lcm_pkg::ACC_W-lcm_pkg::PROD_W){r_prod[lcm_pkg::PROD_W-1]}},
                                  r_prod};
            end
            // A taken item leaves the output register unless a new one replaces it.
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (cmd)
                            lcm_pkg::CMD_LOAD_SIG: begin
                                if (sig_we) begin
                                    r_sig_cnt <= r_sig_cnt + SCW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            lcm_pkg::CMD_LOAD_KER: begin
                                if (ker_we) begin
                                    r_ker_cnt <= r_ker_cnt + KCW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            lcm_pkg::CMD_FETCH: begin
                                r_state <= S_SHAPE;
                            end
                            default: begin
                                r_sig_cnt <= '0;
                                r_ker_cnt <= '0;
                                r_ovf     <= 1'b0;
                            end
                        endcase
                    end
                end
                S_SHAPE: begin
                    r_len   <= n_len_w[NW-1:0];
                    r_start <= n_start;
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    r_empty <= n_empty;
                    r_acc   <= '0;
                    r_j     <= lo[SAW-1:0];
                    r_k     <= k0[KAW-1:0];
                    r_left  <= span[KAW-1:0];
                    if (n_empty || (hi < lo)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_j    <= r_j + SAW'(1);
                    r_k    <= r_k - KAW'(1);
                    r_left <= r_left - KAW'(1);
                    if (r_left == '0) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1 && !r_p2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ovf   <= r_ovf;
                        r_out_none  <= r_empty;
                        if (r_empty) begin
                            r_out_value <= '0;
                            r_out_index <= '0;
                            r_out_last  <= 1'b0;
                        end else begin
                            r_out_value <= r_acc;
                            r_out_index <= idx_ext[lcm_pkg::IDX_W-1:0];
                            r_out_last  <= ((r_next + NW'(1)) == r_len);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A mode write restarts the output sequence.
            if (cfg_we) begin
                r_mode <= i_cfg_data;
            end

            // The output position restarts on a mode write, a stored load or a clear,
            // and steps by one for each delivered output that is not empty.
            if (seq_restart) begin
                r_next <= '0;
            end else if ((r_state == S_DONE) && out_free && !r_empty) begin
                r_next <= r_next + NW'(1);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(lcm_pkg::OUT_DATA_W-lcm_pkg::ACC_W-lcm_pkg::IDX_W){1'b0}},
                            r_out_index, r_out_value};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_ovf, r_out_none};

    // An empty fetch never marks the end of a sequence.
    `LCM_ASSERT(a_none_not_last, i_clk, i_rst_n, !(r_out_valid && r_out_none && r_out_last))
    // Products only flow while a sum is being formed.
    `LCM_ASSERT(a_pipe_in_sum, i_clk, i_rst_n,
        !r_p2 || (r_state == S_RUN) || (r_state == S_DRAIN))
    // The output position never runs past the sequence length.
    `LCM_ASSERT(a_next_in_len, i_clk, i_rst_n, (r_state != S_RANGE) || (r_next <= r_len))
    // Store fill counts stay within the store depths.
    `LCM_ASSERT(a_cnt_bound, i_clk, i_rst_n,
        (r_sig_cnt <= SCW'(SIGNAL_DEPTH)) && (r_ker_cnt <= KCW'(KERNEL_DEPTH)))
    // A delivered output advances the position by one.
    `LCM_ASSERT_NEXT(a_next_step, i_clk, i_rst_n,
        (r_state == S_DONE) && out_free && !r_empty && !i_cfg_valid,
        r_next == $past(r_next) + NW'(1))

endmodule

// ===== sv/lcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module lcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
